[src/esc_pkg.sv]
// shared types, register indexes and the crc-32 byte update for the extract sink
// no dependencies; imported by every module of the block
package esc_pkg;

   // character codes handled by the line-ending conversion
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // reflected crc-32 polynomial
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;

   // register indexes on the csr port (byte address bits [3:2])
   localparam logic [1:0] REG_TEXT_MODE    = 2'd0;
   localparam logic [1:0] REG_TEST_ONLY    = 2'd1;
   localparam logic [1:0] REG_LIMIT_ENABLE = 2'd2;
   localparam logic [1:0] REG_BYTE_LIMIT   = 2'd3;

   // input beat
   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
      logic       last_in_buffer;
   } esc_req_type;

   // result beat
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic [31:0] crc_value;
      logic        overrun;
      logic        buffer_end;
      logic        last_of_run;
   } esc_rsp_type;

   // configuration registers as seen by the front end
   typedef struct packed {
      logic        text_mode;
      logic        test_only;
      logic        limit_enable;
      logic [31:0] byte_limit;
   } esc_cfg_type;

   // what the back end has to do with one classified item
   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_BYTE   = 2'd1,
      KIND_PAIR   = 2'd2
   } esc_kind_type;

   // one entry of the queue between front and back
   typedef struct packed {
      esc_kind_type kind;
      logic [7:0]   data_byte;
      logic [31:0]  crc_value;
      logic         overrun;
      logic         buffer_end;
   } esc_entry_type;

   // one byte through the finished-form crc-32
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = ~crc;
      c[7:0] = c[7:0] ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return ~c;
   endfunction

endpackage

[src/esc_front.sv]
// front end: accepts input beats, runs budget, crc and cr memory, classifies items
// depends on esc_pkg
module esc_front
   import esc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  esc_cfg_type   cfg,
   input  logic          req_push,
   input  esc_req_type   req_data,
   input  logic          q_full,
   output logic          q_push,
   output esc_entry_type q_entry
);

   logic [31:0] crc_ff, crc_in;
   logic        prev_cr_ff, prev_cr_in;
   logic [31:0] left_ff, left_in;

   logic [31:0] crc_base;
   logic        prev_base;
   logic [31:0] left_base;
   logic        drop;
   logic [7:0]  b;

   assign q_push = req_push && !q_full;
   assign b      = req_data.data_byte;

   // start of file clears crc and cr memory and reloads the budget first
   always_comb begin
      crc_base  = req_data.start_of_file ? 32'd0 : crc_ff;
      prev_base = req_data.start_of_file ? 1'b0 : prev_cr_ff;
      left_base = req_data.start_of_file ? cfg.byte_limit : left_ff;
      drop      = cfg.limit_enable && (left_base == 32'd0);
   end

   // classify and compute next state
   always_comb begin
      left_in    = (cfg.limit_enable && !drop) ? left_base - 32'd1 : left_base;
      crc_in     = drop ? crc_base : crc_byte(crc_base, b);
      prev_cr_in = prev_base;

      q_entry.kind       = KIND_STATUS;
      q_entry.data_byte  = 8'd0;
      q_entry.crc_value  = crc_in;
      q_entry.overrun    = drop;
      q_entry.buffer_end = req_data.last_in_buffer;

      if (drop || cfg.test_only) begin
         q_entry.kind = KIND_STATUS;
      end else if (!cfg.text_mode) begin
         q_entry.kind      = KIND_BYTE;
         q_entry.data_byte = b;
      end else if (b == CHAR_LF && prev_base) begin
         // lf right after cr is swallowed
         q_entry.kind = KIND_STATUS;
         prev_cr_in   = 1'b0;
      end else if (b == CHAR_CR || b == CHAR_LF) begin
         q_entry.kind = KIND_PAIR;
         prev_cr_in   = (b == CHAR_CR);
      end else begin
         q_entry.kind      = KIND_BYTE;
         q_entry.data_byte = b;
         prev_cr_in        = 1'b0;
      end
   end

   // state registers update on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= 32'd0;
         prev_cr_ff <= 1'b0;
         left_ff    <= 32'd0;
      end else if (q_push) begin
         crc_ff     <= crc_in;
         prev_cr_ff <= prev_cr_in;
         left_ff    <= left_in;
      end
   end

endmodule

[src/esc_queue.sv]
// short queue of classified items between front and back end
// depends on esc_pkg
module esc_queue
   import esc_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  esc_entry_type push_entry,
   input  logic          pop,
   output logic          full,
   output logic          empty,
   output esc_entry_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   esc_entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[src/esc_back.sv]
// back end: expands queued items into result beats and holds the output register
// depends on esc_pkg
module esc_back
   import esc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  esc_entry_type q_head,
   output logic          q_pop,
   input  logic          rsp_pop,
   output logic          rsp_empty,
   output esc_rsp_type   rsp_data
);

   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'b01,
      PHASE_SECOND = 2'b10
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        out_valid_ff, out_valid_in;
   esc_rsp_type out_data_ff;
   esc_rsp_type beat;
   logic        load;

   assign load      = !q_empty && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   // build the next result beat from the head item
   always_comb begin
      beat.out_byte    = 8'd0;
      beat.byte_valid  = 1'b0;
      beat.crc_value   = q_head.crc_value;
      beat.overrun     = q_head.overrun;
      beat.buffer_end  = q_head.buffer_end;
      beat.last_of_run = 1'b1;
      q_pop            = load;
      phase_in         = phase_ff;
      case (q_head.kind)
         KIND_BYTE: begin
            beat.out_byte   = q_head.data_byte;
            beat.byte_valid = 1'b1;
         end
         KIND_PAIR: begin
            beat.byte_valid = 1'b1;
            case (phase_ff)
               PHASE_FIRST: begin
                  beat.out_byte    = CHAR_CR;
                  beat.buffer_end  = 1'b0;
                  beat.last_of_run = 1'b0;
                  q_pop            = 1'b0;
                  if (load) phase_in = PHASE_SECOND;
               end
               PHASE_SECOND: begin
                  beat.out_byte = CHAR_LF;
                  if (load) phase_in = PHASE_FIRST;
               end
               default: begin
                  beat.out_byte = CHAR_LF;
                  phase_in      = PHASE_FIRST;
               end
            endcase
         end
         default: begin
            beat.out_byte   = 8'd0;
            beat.byte_valid = 1'b0;
         end
      endcase
   end

   // output register valid flag
   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff <= beat;
      end
   end

endmodule

[src/extract_sink_crc_eol_convert_unit.sv]
// top level of the extract sink: csr registers, front end, queue, back end
// depends on esc_pkg, esc_front, esc_queue, esc_back
//
//   channel   ports                      beat / transfer
//   input     req_push req_full req_data push && !full
//   result    rsp_pop rsp_empty rsp_data pop && !empty
//   config    csr_p* (apb style)         psel && penable && pwrite
//
// one input beat per cycle while req_full is low; the front end updates crc,
// budget and cr memory in the accept cycle, so the crc byte step sets the
// front end's rate. a result passes the queue and the output register before
// it reaches the result ports; a cr/lf pair fills the output register with its
// cr beat, then its lf beat, so sustained rate is one result per cycle while
// rsp_pop is high. the queue absorbs bursts of pairs; req_full rises when full.
// synchronous active-high reset clears config, crc, budget, cr memory and queue.
module extract_sink_crc_eol_convert_unit
   import esc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  esc_req_type req_data,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output esc_rsp_type rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   esc_cfg_type   cfg_ff;
   logic          csr_write;
   logic [1:0]    csr_index;
   logic          q_push;
   logic          q_pop;
   logic          q_full;
   logic          q_empty;
   esc_entry_type q_entry;
   esc_entry_type q_head;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_TEXT_MODE:    cfg_ff.text_mode    <= csr_pwdata[0];
            REG_TEST_ONLY:    cfg_ff.test_only    <= csr_pwdata[0];
            REG_LIMIT_ENABLE: cfg_ff.limit_enable <= csr_pwdata[0];
            REG_BYTE_LIMIT:   cfg_ff.byte_limit   <= csr_pwdata;
            default:          cfg_ff              <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_TEXT_MODE:    csr_prdata = {31'd0, cfg_ff.text_mode};
         REG_TEST_ONLY:    csr_prdata = {31'd0, cfg_ff.test_only};
         REG_LIMIT_ENABLE: csr_prdata = {31'd0, cfg_ff.limit_enable};
         REG_BYTE_LIMIT:   csr_prdata = cfg_ff.byte_limit;
         default:          csr_prdata = 32'd0;
      endcase
   end

   assign req_full = q_full;

   esc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   esc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   esc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   // a beat without a byte carries a zero byte
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.byte_valid) |-> (rsp_data.out_byte == 8'd0))
      else $error("status beat carries a nonzero byte");

   // only the cr half of a pair ends without last_of_run
   a_first_half_cr: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.last_of_run) |->
         (rsp_data.out_byte == CHAR_CR && rsp_data.byte_valid && !rsp_data.buffer_end
          && !rsp_data.overrun))
      else $error("non-final beat is not a cr");

   // once the cr half is popped, the lf half follows in the next cycle
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last_of_run) |=>
         (!rsp_empty && rsp_data.out_byte == CHAR_LF && rsp_data.last_of_run))
      else $error("lf half of pair missing");

   // a dropped byte never writes data
   a_overrun_status: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.overrun) |-> !rsp_data.byte_valid)
      else $error("overrun beat carries a byte");

endmodule

[dv/tb_extract_sink_crc_eol_convert_unit.sv]
// testbench for the extract sink: byte budget, crc-32 and cr/lf line-ending conversion
// depends on esc_pkg and extract_sink_crc_eol_convert_unit; beats are checked in order
// against a shadow copy of the sink state kept in the class below
`timescale 1ns / 100ps

import esc_pkg::*;

// shadow of the sink: config, crc, cr memory, budget and the beats still due
class sink_shadow;
   bit          text_mode;
   bit          test_only;
   bit          limit_enable;
   bit [31:0]   byte_limit;
   bit [31:0]   crc;
   bit          cr_seen;
   bit [31:0]   budget;
   esc_rsp_type due_beats[$];
   int          errors;

   function void write_reg(logic [1:0] idx, bit [31:0] value);
      case (idx)
         REG_TEXT_MODE:    text_mode    = value[0];
         REG_TEST_ONLY:    test_only    = value[0];
         REG_LIMIT_ENABLE: limit_enable = value[0];
         REG_BYTE_LIMIT:   byte_limit   = value;
         default: ;
      endcase
   endfunction

   function bit [31:0] read_reg(logic [1:0] idx);
      case (idx)
         REG_TEXT_MODE:    return {31'd0, text_mode};
         REG_TEST_ONLY:    return {31'd0, test_only};
         REG_LIMIT_ENABLE: return {31'd0, limit_enable};
         default:          return byte_limit;
      endcase
   endfunction

   // bit-serial reflected crc-32, one data bit fed per step
   function bit [31:0] crc_next(bit [31:0] c, bit [7:0] d);
      bit [31:0] r;
      bit        fb;
      r = ~c;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ d[i];
         r  = r >> 1;
         if (fb) r = r ^ CRC_POLY;
      end
      return ~r;
   endfunction

   function void add_beat(bit [7:0] ob, bit valid, bit ovr, bit bend, bit last);
      esc_rsp_type b;
      b.out_byte    = ob;
      b.byte_valid  = valid;
      b.crc_value   = crc;
      b.overrun     = ovr;
      b.buffer_end  = bend;
      b.last_of_run = last;
      due_beats.push_back(b);
   endfunction

   // one accepted input beat: update state, queue the beats it causes
   function void take_input(esc_req_type t);
      if (t.start_of_file) begin
         crc     = 32'd0;
         cr_seen = 1'b0;
         budget  = byte_limit;
      end
      // budget check comes first; a dropped byte leaves crc and cr memory alone
      if (limit_enable) begin
         if (budget == 32'd0) begin
            add_beat(8'd0, 1'b0, 1'b1, t.last_in_buffer, 1'b1);
            return;
         end
         budget = budget - 32'd1;
      end
      crc = crc_next(crc, t.data_byte);
      if (test_only) begin
         add_beat(8'd0, 1'b0, 1'b0, t.last_in_buffer, 1'b1);
      end else if (!text_mode) begin
         add_beat(t.data_byte, 1'b1, 1'b0, t.last_in_buffer, 1'b1);
      end else if (t.data_byte == CHAR_LF && cr_seen) begin
         // lf right after cr is swallowed
         cr_seen = 1'b0;
         add_beat(8'd0, 1'b0, 1'b0, t.last_in_buffer, 1'b1);
      end else if (t.data_byte == CHAR_CR || t.data_byte == CHAR_LF) begin
         cr_seen = (t.data_byte == CHAR_CR);
         add_beat(CHAR_CR, 1'b1, 1'b0, 1'b0, 1'b0);
         add_beat(CHAR_LF, 1'b1, 1'b0, t.last_in_buffer, 1'b1);
      end else begin
         cr_seen = 1'b0;
         add_beat(t.data_byte, 1'b1, 1'b0, t.last_in_buffer, 1'b1);
      end
   endfunction

   // one accepted result beat against the oldest one due
   function void match_beat(esc_rsp_type got);
      esc_rsp_type want;
      if (due_beats.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected result beat: byte %h valid %b crc %h ovr %b bend %b last %b",
                     got.out_byte, got.byte_valid, got.crc_value, got.overrun,
                     got.buffer_end, got.last_of_run);
         return;
      end
      want = due_beats.pop_front();
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.crc_value !== want.crc_value || got.overrun !== want.overrun ||
          got.buffer_end !== want.buffer_end || got.last_of_run !== want.last_of_run) begin
         errors++;
         if (errors <= 10) begin
            $display("mismatch: expected byte %h valid %b crc %h ovr %b bend %b last %b",
                     want.out_byte, want.byte_valid, want.crc_value, want.overrun,
                     want.buffer_end, want.last_of_run);
            $display("          actual   byte %h valid %b crc %h ovr %b bend %b last %b",
                     got.out_byte, got.byte_valid, got.crc_value, got.overrun,
                     got.buffer_end, got.last_of_run);
         end
      end
   endfunction

   function int pending();
      return due_beats.size();
   endfunction
endclass

module tb_extract_sink_crc_eol_convert_unit;

   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE      = 12;
   localparam int PHASE_ITEMS = 200;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_push    = 1'b0;
   logic        req_full;
   esc_req_type req_data    = '0;
   logic        rsp_pop     = 1'b0;
   logic        rsp_empty;
   esc_rsp_type rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sink_shadow shadow = new;
   int         req_burst = 0;
   int         rsp_burst = 0;

   extract_sink_crc_eol_convert_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // draw an idle count; bursts of back-to-back beats in between
   function automatic int draw_gap(ref int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         burst = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 9);
   endfunction

   function automatic esc_req_type mk(logic [7:0] d, logic sof, logic lib);
      esc_req_type t;
      t.data_byte      = d;
      t.start_of_file  = sof;
      t.last_in_buffer = lib;
      return t;
   endfunction

   // random beat, heavy on cr and lf so the conversion gets exercised
   function automatic esc_req_type rand_item(int sof_rate);
      logic [7:0] d;
      case ($urandom_range(0, 5))
         0:       d = CHAR_CR;
         1:       d = CHAR_LF;
         default: d = 8'($urandom_range(0, 255));
      endcase
      return mk(d, $urandom_range(0, sof_rate - 1) == 0, 1'($urandom_range(0, 1)));
   endfunction

   // one input beat; push stays high when no gap follows
   task automatic send_item(esc_req_type t);
      int gap;
      gap = draw_gap(req_burst);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (req_full);
      shadow.take_input(t);
   endtask

   // stop pushing and let every due beat come out
   task automatic drain();
      req_push <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
   endtask

   // apb write of one register, then read it back
   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      logic [31:0] want;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      shadow.write_reg(idx, value);
      // read-back setup, psel held
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      want = shadow.read_reg(idx);
      if (csr_prdata !== want) begin
         shadow.errors++;
         if (shadow.errors <= 10)
            $display("register %0d read back: expected %h actual %h", idx, want, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // new setting, only once the block has gone quiet
   task automatic configure(bit tm, bit to, bit le, logic [31:0] lim);
      drain();
      repeat (SETTLE) @(posedge clock);
      write_csr(REG_TEXT_MODE, {31'd0, tm});
      write_csr(REG_TEST_ONLY, {31'd0, to});
      write_csr(REG_LIMIT_ENABLE, {31'd0, le});
      write_csr(REG_BYTE_LIMIT, lim);
   endtask

   // result side: random pop stalls, every beat checked
   initial begin
      int gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         gap = draw_gap(rsp_burst);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         shadow.match_beat(rsp_data);
      end
   end

   // watchdog on cycles with no beat on any channel
   initial begin
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) ||
             (csr_psel && csr_penable) || reset)
            idle = 0;
         else
            idle++;
      end
      $display("timeout: no progress for %0d cycles, %0d beats due", idle, shadow.pending());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      bit [31:0] lim;
      int        sof_rate;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // binary mode from reset values: byte extremes and buffer end flag
      send_item(mk(8'h00, 1'b1, 1'b0));
      send_item(mk(8'hFF, 1'b0, 1'b1));
      send_item(mk(CHAR_CR, 1'b0, 1'b0));
      send_item(mk(CHAR_LF, 1'b0, 1'b1));

      // text mode: pair, swallowed lf, lone lf, cr cr lf, lf across a buffer end
      configure(1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF);
      send_item(mk(CHAR_CR, 1'b1, 1'b1));
      send_item(mk(CHAR_LF, 1'b0, 1'b0));
      send_item(mk(CHAR_LF, 1'b0, 1'b1));
      send_item(mk(CHAR_CR, 1'b0, 1'b0));
      send_item(mk(CHAR_CR, 1'b0, 1'b1));
      send_item(mk(CHAR_LF, 1'b0, 1'b1));
      send_item(mk(8'h41, 1'b0, 1'b0));
      // file start clears the cr memory, so this lf is not swallowed
      send_item(mk(CHAR_CR, 1'b0, 1'b0));
      send_item(mk(CHAR_LF, 1'b1, 1'b0));

      // test mode: no data bytes, cr memory untouched
      configure(1'b1, 1'b1, 1'b0, 32'd0);
      send_item(mk(CHAR_CR, 1'b1, 1'b0));
      send_item(mk(CHAR_LF, 1'b0, 1'b1));

      // budget of two: third and fourth bytes dropped, file start reloads
      configure(1'b0, 1'b0, 1'b1, 32'd2);
      send_item(mk(8'h31, 1'b1, 1'b0));
      send_item(mk(8'h32, 1'b0, 1'b0));
      send_item(mk(8'h33, 1'b0, 1'b1));
      send_item(mk(8'h34, 1'b0, 1'b0));
      send_item(mk(8'h35, 1'b1, 1'b1));

      // zero budget drops everything, also in text mode
      configure(1'b1, 1'b0, 1'b1, 32'd0);
      send_item(mk(CHAR_CR, 1'b1, 1'b1));
      send_item(mk(CHAR_LF, 1'b0, 1'b0));

      // random phases over every mode combination
      for (int p = 0; p < 8; p++) begin
         case (p)
            4:       lim = 32'd0;
            5:       lim = 32'hFFFF_FFFF;
            6, 7:    lim = $urandom_range(1, 24);
            default: lim = $urandom;
         endcase
         sof_rate = (p >= 6) ? 12 : 30;
         configure(p[0], p[1], p[2], lim);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // one hold-off until the block is empty
            if (p == 3 && n == PHASE_ITEMS / 2) drain();
            send_item(rand_item(sof_rate));
         end
      end

      drain();
      repeat (SETTLE * 2) @(posedge clock);
      if (shadow.errors == 0 && shadow.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[filelist.f]
src/esc_pkg.sv
src/esc_front.sv
src/esc_queue.sv
src/esc_back.sv
src/extract_sink_crc_eol_convert_unit.sv
dv/tb_extract_sink_crc_eol_convert_unit.sv
